@@ sv/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/vpm_pkg.sv @@
package vpm_pkg;

    localparam int POS_W   = 26;
    localparam int DIR_W   = 16;
    localparam int ANG_W   = 16;
    localparam int SUM_W   = 21;
    localparam int SPEED_W = 20;
    localparam int OP_W    = 2;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 4;

    // CORDIC datapath width: Q1.30 with headroom for gain and pre-scaling
    localparam int X_W = 34;

    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int TABLE_LEN             = 24;

    localparam logic signed [X_W-1:0] GAIN_Q30 = X_W'(652032874);
    localparam logic signed [X_W-1:0] HALF_TURN = X_W'(64'sd2147483648);
    localparam logic signed [X_W-1:0] QUARTER_TURN = X_W'(64'sd1073741824);
    localparam logic signed [DIR_W-1:0] DIR_ONE = DIR_W'(16384);

    localparam logic [POS_W-1:0]   BOX_RESET   = POS_W'(4194304);
    localparam logic [SPEED_W-1:0] SPEED_RESET = SPEED_W'(32768);

    typedef enum logic [1:0] {
        REG_BOX_WIDTH  = 2'd0,
        REG_BOX_HEIGHT = 2'd1,
        REG_SPEED      = 2'd2,
        REG_NONE       = 2'd3
    } t_reg;

    typedef enum logic [OP_W-1:0] {
        OP_PLACE = 2'd0,
        OP_SUM   = 2'd1,
        OP_MOVE  = 2'd2,
        OP_HOLD  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_VPRE,
        S_VEC,
        S_RPRE,
        S_ROT,
        S_ROUND,
        S_MUL,
        S_WRAP,
        S_OUT
    } t_state;

    // atan(2^-i) as a 32-bit binary angle
    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10680862;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

@@ sv/vicsek_particle_move_top.sv @@
`include "assert_macros.svh"
// Self-propelled particle in a periodic box, one particle per instance.
// Input channel: i_in_valid / o_in_stall carries one command beat (op, load
// position, angle, velocity sum). Output channel: o_out_valid / i_out_stall
// returns one result beat per command: position, unit direction, zero flag.
// A beat moves when valid is high and stall is low at a rising edge.
// All trig and normalization run on one CORDIC unit (N = CORDIC_ITERATIONS
// micro-rotations, one per cycle), sequenced by a small state machine, so
// the block holds o_in_stall high while a command is in flight.
// Steps from accept to result beat:
//   place        rotation, round
//   velocity sum vectoring, rotation, round; output only when the sum is zero
//   move         vectoring, rotation, then two multiply/wrap steps
//   op 3         output only
// The CORDIC iteration count sets the rate; the next command is taken once
// the result is registered.
// A finished result waits in the output register; while the receiver stalls
// the block still takes and works the next command, and holds before
// loading its result until the output register is free.
// Reset (synchronous, active low): position 0, direction unit along x,
// box 64.0 by 64.0, speed 0.5, no result pending. The user must make config
// writes through the APB port only while no command is in flight (unenforced).
module vicsek_particle_move_top #(
    parameter int CORDIC_ITERATIONS = vpm_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // command channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [vpm_pkg::OP_W-1:0]           i_op,
    input  logic [vpm_pkg::POS_W-1:0]          i_load_x,
    input  logic [vpm_pkg::POS_W-1:0]          i_load_y,
    input  logic signed [vpm_pkg::ANG_W-1:0]   i_angle,
    input  logic signed [vpm_pkg::SUM_W-1:0]   i_sum_x,
    input  logic signed [vpm_pkg::SUM_W-1:0]   i_sum_y,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [vpm_pkg::POS_W-1:0]          o_out_x,
    output logic [vpm_pkg::POS_W-1:0]          o_out_y,
    output logic signed [vpm_pkg::DIR_W-1:0]   o_out_dir_x,
    output logic signed [vpm_pkg::DIR_W-1:0]   o_out_dir_y,
    output logic                               o_zero_vector,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [vpm_pkg::APB_AW-1:0]         paddr,
    input  logic [vpm_pkg::APB_DW-1:0]         pwdata,
    output logic [vpm_pkg::APB_DW-1:0]         prdata,
    output logic                               pready
);
    import vpm_pkg::*;

    localparam int ITER_W = $clog2(CORDIC_ITERATIONS);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_ITERATIONS - 1);
    localparam int PROD_W = SPEED_W + 1 + DIR_W;
    localparam int DISP_W = PROD_W - (DIR_W - 2);
    localparam int WRAP_W = POS_W + 2;

    // Round a Q1.30 CORDIC output to Q1.14, clamp to the unit, apply the flip.
    function automatic logic signed [DIR_W-1:0] round_dir(
        input logic signed [X_W-1:0] v,
        input logic                  neg
    );
        logic signed [X_W:0]    s;
        logic signed [X_W-16:0] r;
        logic signed [DIR_W-1:0] c;
        s = {v[X_W-1], v} + (X_W+1)'(32768);
        r = s[X_W:16];
        if (r > (X_W-15)'(16384)) begin
            c = DIR_ONE;
        end else if (r < -(X_W-15)'(16384)) begin
            c = -DIR_ONE;
        end else begin
            c = DIR_W'(r);
        end
        return neg ? -c : c;
    endfunction

    // configuration registers
    logic [POS_W-1:0]   r_box_w, r_box_h;
    logic [SPEED_W-1:0] r_speed;

    // particle state
    logic [POS_W-1:0]        r_pos_x, n_pos_x;
    logic [POS_W-1:0]        r_pos_y, n_pos_y;
    logic signed [DIR_W-1:0] r_dir_x, n_dir_x;
    logic signed [DIR_W-1:0] r_dir_y, n_dir_y;

    // sequencer and CORDIC unit
    t_state                  r_state, n_state;
    t_op                     r_op, n_op;
    logic signed [X_W-1:0]   r_x, n_x;
    logic signed [X_W-1:0]   r_y, n_y;
    logic signed [X_W-1:0]   r_z, n_z;
    logic [31:0]             r_angle_add, n_angle_add;
    logic [ITER_W-1:0]       r_iter, n_iter;
    logic                    r_flip, n_flip;
    logic                    r_zero, n_zero;
    logic                    r_axis, n_axis;
    logic signed [PROD_W-1:0] r_prod, n_prod;

    // result register
    logic                    r_out_valid, n_out_valid;
    logic [POS_W-1:0]        r_out_x, n_out_x;
    logic [POS_W-1:0]        r_out_y, n_out_y;
    logic signed [DIR_W-1:0] r_out_dx, n_out_dx;
    logic signed [DIR_W-1:0] r_out_dy, n_out_dy;
    logic                    r_out_zero, n_out_zero;

    // shared unit signals
    logic signed [X_W-1:0]   sh_x, sh_y, atan_v, rz;
    logic                    ccw;
    logic signed [X_W-1:0]   step_x, step_y, step_z;
    logic signed [SPEED_W:0] mul_a;
    logic signed [DIR_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod, prod_rnd;
    logic signed [DISP_W-1:0] disp;
    logic signed [WRAP_W-1:0] p_sum, p_less, p_more, box_s;
    logic [POS_W-1:0]        pos_cur, pos_new;
    logic [31:0]             a_sum;
    logic                    slot_free, cfg_wr;
    t_reg                    cfg_reg;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_reg = t_reg'(paddr[3:2]);

    always_comb begin
        case (cfg_reg)
            REG_BOX_WIDTH:  prdata = APB_DW'(r_box_w);
            REG_BOX_HEIGHT: prdata = APB_DW'(r_box_h);
            REG_SPEED:      prdata = APB_DW'(r_speed);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_w <= BOX_RESET;
            r_box_h <= BOX_RESET;
            r_speed <= SPEED_RESET;
        end else if (cfg_wr) begin
            case (cfg_reg)
                REG_BOX_WIDTH:  r_box_w <= pwdata[POS_W-1:0];
                REG_BOX_HEIGHT: r_box_h <= pwdata[POS_W-1:0];
                REG_SPEED:      r_speed <= pwdata[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- shared CORDIC micro-rotation ----------------
    // Vectoring drives y toward zero, rotation drives z toward zero; both use
    // the same add/shift unit, only the direction decision differs.
    assign sh_x   = r_x >>> r_iter;
    assign sh_y   = r_y >>> r_iter;
    assign atan_v = $signed({2'b00, atan_entry(5'(r_iter))});
    assign ccw    = (r_state == S_VEC) ? r_y[X_W-1] : ~r_z[X_W-1];
    assign step_x = ccw ? r_x - sh_y : r_x + sh_y;
    assign step_y = ccw ? r_y + sh_x : r_y - sh_x;
    assign step_z = ccw ? r_z - atan_v : r_z + atan_v;

    // rotation start angle: vectoring result plus turn, wrapped to 32 bits
    assign a_sum = r_z[31:0] + r_angle_add;
    assign rz    = {{(X_W-32){a_sum[31]}}, a_sum};

    // ---------------- displacement multiply and wrap ----------------
    assign mul_a    = $signed({1'b0, r_speed});
    assign mul_b    = r_axis ? r_dir_y : r_dir_x;
    assign prod     = mul_a * mul_b;
    assign prod_rnd = r_prod + PROD_W'(8192);
    assign disp     = prod_rnd[PROD_W-1:DIR_W-2];
    assign pos_cur  = r_axis ? r_pos_y : r_pos_x;
    assign box_s    = $signed({2'b00, (r_axis ? r_box_h : r_box_w)});
    assign p_sum    = $signed({2'b00, pos_cur}) + {{(WRAP_W-DISP_W){disp[DISP_W-1]}}, disp};
    assign p_less   = p_sum - box_s;
    assign p_more   = p_sum + box_s;

    // wrap once: subtract the box at or past its end, add it below zero
    always_comb begin
        if (!p_less[WRAP_W-1]) begin
            pos_new = p_less[POS_W-1:0];
        end else if (p_sum[WRAP_W-1]) begin
            pos_new = p_more[POS_W-1:0];
        end else begin
            pos_new = p_sum[POS_W-1:0];
        end
    end

    assign slot_free = ~r_out_valid | ~i_out_stall;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_angle_add = r_angle_add;
        n_iter      = r_iter;
        n_flip      = r_flip;
        n_zero      = r_zero;
        n_axis      = r_axis;
        n_prod      = r_prod;
        n_pos_x     = r_pos_x;
        n_pos_y     = r_pos_y;
        n_dir_x     = r_dir_x;
        n_dir_y     = r_dir_y;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_dx    = r_out_dx;
        n_out_dy    = r_out_dy;
        n_out_zero  = r_out_zero;
        n_out_valid = r_out_valid & i_out_stall;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op        = t_op'(i_op);
                    n_zero      = 1'b0;
                    n_angle_add = '0;
                    n_iter      = '0;
                    n_axis      = 1'b0;
                    case (t_op'(i_op))
                        OP_PLACE: begin
                            n_pos_x     = i_load_x;
                            n_pos_y     = i_load_y;
                            n_z         = '0;
                            n_angle_add = {i_angle, 16'h0000};
                            n_state     = S_RPRE;
                        end
                        OP_SUM: begin
                            if (i_sum_x == '0 && i_sum_y == '0) begin
                                n_zero  = 1'b1;
                                n_state = S_OUT;
                            end else begin
                                n_x     = {{(X_W-SUM_W-10){i_sum_x[SUM_W-1]}}, i_sum_x, 10'h000};
                                n_y     = {{(X_W-SUM_W-10){i_sum_y[SUM_W-1]}}, i_sum_y, 10'h000};
                                n_state = S_VPRE;
                            end
                        end
                        OP_MOVE: begin
                            n_x         = {{(X_W-DIR_W-10){r_dir_x[DIR_W-1]}}, r_dir_x, 10'h000};
                            n_y         = {{(X_W-DIR_W-10){r_dir_y[DIR_W-1]}}, r_dir_y, 10'h000};
                            n_angle_add = {i_angle, 16'h0000};
                            n_state     = S_VPRE;
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_VPRE: begin
                // fold the left half plane over by a half turn
                if (r_x[X_W-1]) begin
                    n_x = -r_x;
                    n_y = -r_y;
                    n_z = HALF_TURN;
                end else begin
                    n_z = '0;
                end
                n_iter  = '0;
                n_state = S_VEC;
            end
            S_VEC: begin
                n_x    = step_x;
                n_y    = step_y;
                n_z    = step_z;
                n_iter = r_iter + 1'b1;
                if (r_iter == ITER_LAST) begin
                    n_state = S_RPRE;
                end
            end
            S_RPRE: begin
                // reduce into the right half plane, remember the flip
                n_flip = 1'b0;
                n_z    = rz;
                if (rz > QUARTER_TURN) begin
                    n_z    = rz - HALF_TURN;
                    n_flip = 1'b1;
                end else if (rz < -QUARTER_TURN) begin
                    n_z    = rz + HALF_TURN;
                    n_flip = 1'b1;
                end
                n_x     = GAIN_Q30;
                n_y     = '0;
                n_iter  = '0;
                n_state = S_ROT;
            end
            S_ROT: begin
                n_x    = step_x;
                n_y    = step_y;
                n_z    = step_z;
                n_iter = r_iter + 1'b1;
                if (r_iter == ITER_LAST) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                n_dir_x = round_dir(r_x, r_flip);
                n_dir_y = round_dir(r_y, r_flip);
                n_axis  = 1'b0;
                n_state = (r_op == OP_MOVE) ? S_MUL : S_OUT;
            end
            S_MUL: begin
                n_prod  = prod;
                n_state = S_WRAP;
            end
            S_WRAP: begin
                if (r_axis) begin
                    n_pos_y = pos_new;
                    n_state = S_OUT;
                end else begin
                    n_pos_x = pos_new;
                    n_axis  = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_OUT: begin
                // hold until the result register is free, then load it
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_x     = r_pos_x;
                    n_out_y     = r_pos_y;
                    n_out_dx    = r_dir_x;
                    n_out_dy    = r_dir_y;
                    n_out_zero  = r_zero;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_dir_x     <= DIR_ONE;
            r_dir_y     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
            r_dir_x     <= n_dir_x;
            r_dir_y     <= n_dir_y;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_x         <= n_x;
        r_y         <= n_y;
        r_z         <= n_z;
        r_angle_add <= n_angle_add;
        r_iter      <= n_iter;
        r_flip      <= n_flip;
        r_zero      <= n_zero;
        r_axis      <= n_axis;
        r_prod      <= n_prod;
        r_out_x     <= n_out_x;
        r_out_y     <= n_out_y;
        r_out_dx    <= n_out_dx;
        r_out_dy    <= n_out_dy;
        r_out_zero  <= n_out_zero;
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_out_x       = r_out_x;
    assign o_out_y       = r_out_y;
    assign o_out_dir_x   = r_out_dx;
    assign o_out_dir_y   = r_out_dy;
    assign o_zero_vector = r_out_zero;

    // ---------------- assertions ----------------
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, (r_state == S_OUT && r_out_valid && i_out_stall), (r_state == S_OUT && o_out_valid), "result loaded over a stalled beat")
    `ASSERT_NEXT(a_iter_start, i_clk, i_rst_n, (r_state == S_VPRE || r_state == S_RPRE), (r_iter == '0), "CORDIC pass did not start at step zero")
    `ASSERT_IMPL(a_dir_unit, i_clk, i_rst_n, o_out_valid, (o_out_dir_x <= DIR_ONE && o_out_dir_x >= -DIR_ONE && o_out_dir_y <= DIR_ONE && o_out_dir_y >= -DIR_ONE), "direction beyond unit range")

endmodule
